// ===== sv/srm_pkg.sv =====
// Shared types and constants for the SPI slave register map.
package srm_pkg;

    localparam int MAP_DEPTH = 256;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int DATA_W    = 8;
    localparam int CNT_W     = 16;
    localparam int MODE_W    = 2;
    localparam int OP_W      = 3;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 24;

    typedef enum logic [OP_W-1:0] {
        OP_SPI        = 3'd0,
        OP_HOST_WRITE = 3'd1,
        OP_HOST_READ  = 3'd2,
        OP_SET_PTR    = 3'd3,
        OP_START      = 3'd4,
        OP_STOP       = 3'd5
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ       = 2'd0,
        MODE_WRITE      = 2'd1,
        MODE_ADDR_READ  = 2'd2,
        MODE_ADDR_WRITE = 2'd3
    } mode_t;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_GCOUNT = 2'd1;
    localparam logic [1:0] REG_GLEN   = 2'd2;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } wr_req_t;

endpackage

// ===== sv/srm_store.sv =====
// Register store: synchronous byte memory with per-entry valid bits, unwritten reads as zero.
module srm_store
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  srm_pkg::rd_req_t          rd,
    input  srm_pkg::wr_req_t          wr,
    output logic [srm_pkg::DATA_W-1:0] rd_data
);

    logic [srm_pkg::DATA_W-1:0]    data_reg [srm_pkg::MAP_DEPTH];
    logic [srm_pkg::MAP_DEPTH-1:0] valid_reg;
    logic [srm_pkg::DATA_W-1:0]    rd_q_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            data_reg[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_q_reg <= data_reg[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_valid_reg <= valid_reg[rd.addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

// ===== sv/spi_slave_register_map.sv =====
// Top level: SPI slave register map with auto-increment pointer and APB configuration.
//
//  channel   dir   handshake                 payload
//  s_*       in    s_tvalid/s_tready         tuser op, tdata {data, address}
//  m_*       out   m_tvalid/m_tready         tdata {session_active, accepted, read_data, tx_byte}
//  apb       in    psel/penable (pready=1)   mode, group_count, group_length
//
//  A beat is accepted in IDLE, which issues the store read; EXEC then executes it and writes back
//  on the registered read data; the store read is registered, so execution follows in EXEC.
//  The next beat is taken while a result waits, as long as the output register frees.
//  Reset clears the per-entry valid bits at once; no clearing pass is needed.
//  A stalled result holds the output register and blocks the next accept.
module spi_slave_register_map
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [srm_pkg::IN_W-1:0]      s_tdata,   // [7:0] address, [15:8] data
    input  logic [srm_pkg::OP_W-1:0]      s_tuser,   // [2:0] operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [srm_pkg::OUT_W-1:0]     m_tdata,   // [7:0] tx_byte, [15:8] read_data,
                                                     // [16] accepted, [17] session_active
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srm_pkg::PADDR_W-1:0]   paddr,
    input  logic [srm_pkg::PDATA_W-1:0]   pwdata,
    output logic [srm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                       state_reg, state_next;
    srm_pkg::op_t                 op_reg;
    logic [srm_pkg::ADDR_W-1:0]   addr_reg;
    logic [srm_pkg::DATA_W-1:0]   data_reg;
    logic [srm_pkg::ADDR_W-1:0]   ptr_reg, ptr_next;
    logic                         latched_reg, latched_next;
    logic [srm_pkg::CNT_W-1:0]    xfer_idx_reg, xfer_idx_next;
    logic [srm_pkg::CNT_W-1:0]    grp_idx_reg, grp_idx_next;
    logic                         running_reg, running_next;
    srm_pkg::mode_t               mode_reg;
    logic [srm_pkg::CNT_W-1:0]    gcount_reg, glen_reg;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [srm_pkg::OUT_W-1:0]    m_tdata_reg, m_tdata_next;

    srm_pkg::rd_req_t             rd_req;
    srm_pkg::wr_req_t             wr_req;
    logic [srm_pkg::DATA_W-1:0]   mem_rdata;
    logic                         in_beat;
    logic                         cfg_wr;

    srm_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (rd_req),
        .wr      (wr_req),
        .rd_data (mem_rdata)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        rd_req.en   = in_beat;
        rd_req.addr = (srm_pkg::op_t'(s_tuser) == srm_pkg::OP_SPI) ?
                      ptr_reg : s_tdata[srm_pkg::ADDR_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            srm_pkg::REG_MODE:   prdata = {{(srm_pkg::PDATA_W-srm_pkg::MODE_W){1'b0}}, mode_reg};
            srm_pkg::REG_GCOUNT: prdata = {{(srm_pkg::PDATA_W-srm_pkg::CNT_W){1'b0}}, gcount_reg};
            srm_pkg::REG_GLEN:   prdata = {{(srm_pkg::PDATA_W-srm_pkg::CNT_W){1'b0}}, glen_reg};
            default:             prdata = '0;
        endcase
    end

    always_comb
    begin
        logic [srm_pkg::ADDR_W-1:0] step_ptr;
        logic [srm_pkg::CNT_W-1:0]  xfer_inc;
        logic [srm_pkg::CNT_W-1:0]  grp_inc;
        logic [srm_pkg::DATA_W-1:0] tx;
        logic [srm_pkg::DATA_W-1:0] rd;
        logic                       acc;
        logic                       plain;

        state_next    = state_reg;
        ptr_next      = ptr_reg;
        latched_next  = latched_reg;
        xfer_idx_next = xfer_idx_reg;
        grp_idx_next  = grp_idx_reg;
        running_next  = running_reg;
        wr_req        = '0;
        tx            = '0;
        rd            = '0;
        acc           = 1'b0;
        step_ptr      = ptr_reg + srm_pkg::ADDR_W'(1);
        xfer_inc      = xfer_idx_reg + srm_pkg::CNT_W'(1);
        grp_inc       = grp_idx_reg + srm_pkg::CNT_W'(1);
        plain         = (mode_reg == srm_pkg::MODE_READ) || (mode_reg == srm_pkg::MODE_WRITE);
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (op_reg)
                    srm_pkg::OP_SPI:
                    begin
                        tx = mem_rdata;
                        if (running_reg)
                        begin
                            acc = 1'b1;
                            unique case (mode_reg)
                                srm_pkg::MODE_READ:
                                begin
                                end
                                srm_pkg::MODE_WRITE:
                                begin
                                    wr_req.en   = 1'b1;
                                    wr_req.addr = ptr_reg;
                                    wr_req.data = data_reg;
                                end
                                srm_pkg::MODE_ADDR_READ:
                                begin
                                    if (data_reg != '0)
                                    begin
                                        step_ptr = data_reg[srm_pkg::ADDR_W-1:0];
                                    end
                                end
                                srm_pkg::MODE_ADDR_WRITE:
                                begin
                                    if (!latched_reg)
                                    begin
                                        step_ptr     = data_reg[srm_pkg::ADDR_W-1:0];
                                        latched_next = 1'b1;
                                    end
                                    else
                                    begin
                                        wr_req.en   = 1'b1;
                                        wr_req.addr = ptr_reg;
                                        wr_req.data = data_reg;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                            ptr_next      = step_ptr;
                            xfer_idx_next = xfer_inc;
                            if (xfer_inc >= glen_reg)
                            begin
                                // group done: rewind by the group length
                                ptr_next      = step_ptr - glen_reg[srm_pkg::ADDR_W-1:0];
                                xfer_idx_next = '0;
                                if (plain)
                                begin
                                    grp_idx_next = grp_inc;
                                    if (grp_inc >= gcount_reg)
                                    begin
                                        running_next = 1'b0;
                                    end
                                end
                                else
                                begin
                                    running_next = 1'b0;
                                    latched_next = 1'b0;
                                end
                            end
                        end
                    end
                    srm_pkg::OP_HOST_WRITE:
                    begin
                        wr_req.en   = 1'b1;
                        wr_req.addr = addr_reg;
                        wr_req.data = data_reg;
                    end
                    srm_pkg::OP_HOST_READ:
                    begin
                        rd = mem_rdata;
                    end
                    srm_pkg::OP_SET_PTR:
                    begin
                        ptr_next = addr_reg;
                    end
                    srm_pkg::OP_START:
                    begin
                        running_next  = 1'b1;
                        xfer_idx_next = '0;
                        grp_idx_next  = '0;
                        if ((glen_reg == '0) || (plain && (gcount_reg == '0)))
                        begin
                            running_next = 1'b0;
                            if (!plain)
                            begin
                                latched_next = 1'b0;
                            end
                        end
                    end
                    srm_pkg::OP_STOP:
                    begin
                        running_next = 1'b0;
                        latched_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
                m_tvalid_next = 1'b1;
                m_tdata_next  = {{(srm_pkg::OUT_W-2*srm_pkg::DATA_W-2){1'b0}},
                                 running_next, acc, rd, tx};
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            op_reg   <= srm_pkg::op_t'(s_tuser);
            addr_reg <= s_tdata[srm_pkg::ADDR_W-1:0];
            data_reg <= s_tdata[2*srm_pkg::DATA_W-1:srm_pkg::DATA_W];
        end
        if (state_reg == ST_EXEC)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ptr_reg      <= '0;
            latched_reg  <= 1'b0;
            xfer_idx_reg <= '0;
            grp_idx_reg  <= '0;
            running_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            mode_reg     <= srm_pkg::MODE_READ;
            gcount_reg   <= srm_pkg::CNT_W'(1);
            glen_reg     <= srm_pkg::CNT_W'(1);
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            latched_reg  <= latched_next;
            xfer_idx_reg <= xfer_idx_next;
            grp_idx_reg  <= grp_idx_next;
            running_reg  <= running_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    srm_pkg::REG_MODE:   mode_reg   <= srm_pkg::mode_t'(pwdata[srm_pkg::MODE_W-1:0]);
                    srm_pkg::REG_GCOUNT: gcount_reg <= pwdata[srm_pkg::CNT_W-1:0];
                    srm_pkg::REG_GLEN:   glen_reg   <= pwdata[srm_pkg::CNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> !s_tready)
        else $error("beat accepted during execute");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == ST_EXEC))
        else $error("accepted beat did not enter execute");

    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> m_tvalid)
        else $error("execute produced no result");

    a_accepted_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[16]) |-> (m_tdata[15:8] == '0))
        else $error("accepted SPI beat carries read data");
`endif

endmodule

// ===== tb/register_map_checker.sv =====
// Watches the stream and APB channels of the register map, predicts each reply and compares.
module register_map_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [srm_pkg::IN_W-1:0]    s_tdata,   // [7:0] address, [15:8] data
    input  logic [srm_pkg::OP_W-1:0]    s_tuser,   // [2:0] operation
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [srm_pkg::OUT_W-1:0]   m_tdata,   // [7:0] tx_byte, [15:8] read_data,
                                                   // [16] accepted, [17] session_active
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srm_pkg::PADDR_W-1:0] paddr,
    input  logic [srm_pkg::PDATA_W-1:0] pwdata,
    input  logic                        pready,
    output int                          mismatches,
    output int                          replies_seen,
    output int                          replies_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [srm_pkg::DATA_W-1:0] tx_byte;
        logic [srm_pkg::DATA_W-1:0] read_data;
        logic                       accepted;
        logic                       session_active;
    } reply_t;

    logic [srm_pkg::DATA_W-1:0] map_mirror [srm_pkg::MAP_DEPTH];
    logic [srm_pkg::ADDR_W-1:0] ptr;
    logic                       addr_latched;
    logic [srm_pkg::CNT_W-1:0]  xfer_idx;
    logic [srm_pkg::CNT_W-1:0]  grp_idx;
    logic                       running;
    srm_pkg::mode_t             cfg_mode;
    logic [srm_pkg::CNT_W-1:0]  cfg_groups;
    logic [srm_pkg::CNT_W-1:0]  cfg_len;
    reply_t                     due_replies[$];
    int                         errs;
    int                         seen;

    function automatic void end_session();
        running = 1'b0;
        if (cfg_mode >= srm_pkg::MODE_ADDR_READ)
            addr_latched = 1'b0;
    endfunction

    function automatic reply_t step_beat(input logic [srm_pkg::OP_W-1:0] op,
                                         input logic [srm_pkg::ADDR_W-1:0] addr,
                                         input logic [srm_pkg::DATA_W-1:0] din);
        reply_t r;
        r = '0;
        case (op)
            srm_pkg::OP_SPI:
            begin
                r.tx_byte = map_mirror[ptr];
                if (running)
                begin
                    r.accepted = 1'b1;
                    case (cfg_mode)
                        srm_pkg::MODE_READ:
                            ptr = ptr + 1'b1;
                        srm_pkg::MODE_WRITE:
                        begin
                            map_mirror[ptr] = din;
                            ptr = ptr + 1'b1;
                        end
                        srm_pkg::MODE_ADDR_READ:
                            ptr = (din != '0) ? din : ptr + 1'b1;
                        default:
                        begin
                            if (!addr_latched)
                            begin
                                ptr = din;
                                addr_latched = 1'b1;
                            end
                            else
                            begin
                                map_mirror[ptr] = din;
                                ptr = ptr + 1'b1;
                            end
                        end
                    endcase
                    xfer_idx = xfer_idx + 1'b1;
                    if (xfer_idx >= cfg_len)
                    begin
                        // rewind by the group length, modulo the map size
                        ptr = ptr - cfg_len[srm_pkg::ADDR_W-1:0];
                        xfer_idx = '0;
                        if (cfg_mode < srm_pkg::MODE_ADDR_READ)
                        begin
                            grp_idx = grp_idx + 1'b1;
                            if (grp_idx >= cfg_groups)
                                end_session();
                        end
                        else
                            end_session();
                    end
                end
            end
            srm_pkg::OP_HOST_WRITE:
                map_mirror[addr] = din;
            srm_pkg::OP_HOST_READ:
                r.read_data = map_mirror[addr];
            srm_pkg::OP_SET_PTR:
                ptr = addr;
            srm_pkg::OP_START:
            begin
                running = 1'b1;
                xfer_idx = '0;
                grp_idx = '0;
                if (cfg_len == '0 ||
                    (cfg_mode < srm_pkg::MODE_ADDR_READ && cfg_groups == '0))
                    end_session();
            end
            srm_pkg::OP_STOP:
            begin
                running = 1'b0;
                addr_latched = 1'b0;
            end
            default:
                ;
        endcase
        r.session_active = running;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want;
        reply_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < srm_pkg::MAP_DEPTH; i++)
                map_mirror[i] = '0;
            ptr = '0;
            addr_latched = 1'b0;
            xfer_idx = '0;
            grp_idx = '0;
            running = 1'b0;
            cfg_mode = srm_pkg::MODE_READ;
            cfg_groups = 16'd1;
            cfg_len = 16'd1;
            due_replies.delete();
            errs = 0;
            seen = 0;
            mismatches <= 0;
            replies_seen <= 0;
            replies_due <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[srm_pkg::PADDR_W-1:2])
                    srm_pkg::REG_MODE:
                        cfg_mode = srm_pkg::mode_t'(pwdata[srm_pkg::MODE_W-1:0]);
                    srm_pkg::REG_GCOUNT:
                        cfg_groups = pwdata[srm_pkg::CNT_W-1:0];
                    srm_pkg::REG_GLEN:
                        cfg_len = pwdata[srm_pkg::CNT_W-1:0];
                    default:
                        ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got.tx_byte = m_tdata[7:0];
                got.read_data = m_tdata[15:8];
                got.accepted = m_tdata[16];
                got.session_active = m_tdata[17];
                seen++;
                if (due_replies.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("%t unexpected reply tx %h rd %h acc %b act %b", $realtime,
                                 got.tx_byte, got.read_data, got.accepted, got.session_active);
                end
                else
                begin
                    want = due_replies.pop_front();
                    if (got !== want)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display({"%t reply %0d: want tx %h rd %h acc %b act %b, ",
                                      "got tx %h rd %h acc %b act %b"},
                                     $realtime, seen, want.tx_byte, want.read_data,
                                     want.accepted, want.session_active, got.tx_byte,
                                     got.read_data, got.accepted, got.session_active);
                    end
                end
            end
            if (s_tvalid && s_tready)
                due_replies.push_back(step_beat(s_tuser, s_tdata[srm_pkg::ADDR_W-1:0],
                                                s_tdata[srm_pkg::DATA_W +: srm_pkg::DATA_W]));
            mismatches <= errs;
            replies_seen <= seen;
            replies_due <= due_replies.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the register map testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [srm_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [srm_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int RANDOM_BEATS = 1900;

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [srm_pkg::IN_W-1:0]    s_tdata = '0;
    logic [srm_pkg::OP_W-1:0]    s_tuser = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [srm_pkg::OUT_W-1:0]   m_tdata;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [srm_pkg::PADDR_W-1:0] paddr = '0;
    logic [srm_pkg::PDATA_W-1:0] pwdata = '0;
    logic [srm_pkg::PDATA_W-1:0] prdata;
    logic                        pready;
    int                          mismatches;
    int                          replies_seen;
    int                          replies_due;
    bit                          idle_on = 1'b1;
    int                          beats_sent = 0;
    int                          settings_used = 0;

    spi_slave_register_map i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    register_map_checker i_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .replies_seen (replies_seen),
        .replies_due  (replies_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= !idle_on || ($urandom_range(99) >= 12);

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_beat(input logic [srm_pkg::OP_W-1:0] op,
                             input logic [srm_pkg::ADDR_W-1:0] addr,
                             input logic [srm_pkg::DATA_W-1:0] din);
        if (idle_on && $urandom_range(99) < 12)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {din, addr};
        do @(posedge clk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_due != 0)
            @(posedge clk);
    endtask

    // leaves psel high so back-to-back writes run with no idle phase between them
    task automatic apb_write(input logic [1:0] idx, input logic [srm_pkg::PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic configure(input srm_pkg::mode_t m, input logic [srm_pkg::CNT_W-1:0] groups,
                             input logic [srm_pkg::CNT_W-1:0] len);
        wait_drained();
        apb_write(srm_pkg::REG_MODE, srm_pkg::PDATA_W'(m));
        apb_write(srm_pkg::REG_GCOUNT, srm_pkg::PDATA_W'(groups));
        apb_write(srm_pkg::REG_GLEN, srm_pkg::PDATA_W'(len));
        psel <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : stimulus
        int                        r;
        int                        k;
        int                        phase_len;
        int                        sess_left;
        int                        rand_start;
        srm_pkg::mode_t            cur_mode;
        logic [srm_pkg::CNT_W-1:0] gc;
        logic [srm_pkg::CNT_W-1:0] gl;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: plain read, one group of one byte
        send_beat(srm_pkg::OP_SPI, 8'h00, 8'hFF);
        send_beat(srm_pkg::OP_HOST_WRITE, 8'hFF, 8'hFF);
        send_beat(srm_pkg::OP_HOST_WRITE, 8'h00, 8'hA5);
        send_beat(srm_pkg::OP_HOST_READ, 8'hFF, 8'h00);
        send_beat(srm_pkg::OP_SET_PTR, 8'hFF, 8'h00);
        send_beat(srm_pkg::OP_START, 8'h00, 8'h00);
        send_beat(srm_pkg::OP_SPI, 8'h00, 8'h00);
        send_beat(OP_SPARE_LO, 8'hFF, 8'hFF);
        send_beat(OP_SPARE_HI, 8'h00, 8'h00);

        configure(srm_pkg::MODE_WRITE, 16'd2, 16'd2);
        send_beat(srm_pkg::OP_START, 8'h00, 8'h00);
        send_beat(srm_pkg::OP_SPI, 8'h00, 8'h5A);
        send_beat(srm_pkg::OP_SPI, 8'h00, 8'hFF);
        send_beat(srm_pkg::OP_SPI, 8'h00, 8'h00);
        send_beat(srm_pkg::OP_SPI, 8'h00, 8'h81);
        send_beat(srm_pkg::OP_SPI, 8'h00, 8'h33);

        configure(srm_pkg::MODE_ADDR_WRITE, 16'd1, 16'd3);
        send_beat(srm_pkg::OP_START, 8'h00, 8'h00);
        send_beat(srm_pkg::OP_SPI, 8'h00, 8'hFE);
        send_beat(srm_pkg::OP_SPI, 8'h00, 8'h11);
        send_beat(srm_pkg::OP_SPI, 8'h00, 8'h22);
        send_beat(srm_pkg::OP_START, 8'h00, 8'h00);
        send_beat(srm_pkg::OP_SPI, 8'h00, 8'h10);
        send_beat(srm_pkg::OP_START, 8'h00, 8'h00);
        send_beat(srm_pkg::OP_STOP, 8'h00, 8'h00);

        configure(srm_pkg::MODE_ADDR_READ, 16'd1, 16'd2);
        send_beat(srm_pkg::OP_START, 8'h00, 8'h00);
        send_beat(srm_pkg::OP_SPI, 8'h00, 8'h00);
        send_beat(srm_pkg::OP_SPI, 8'h00, 8'h80);

        // empty sessions
        configure(srm_pkg::MODE_READ, 16'd0, 16'd4);
        send_beat(srm_pkg::OP_START, 8'h00, 8'h00);
        configure(srm_pkg::MODE_ADDR_READ, 16'd5, 16'd0);
        send_beat(srm_pkg::OP_START, 8'h00, 8'h00);

        rand_start = beats_sent;
        while (beats_sent - rand_start < RANDOM_BEATS)
        begin
            cur_mode = srm_pkg::mode_t'($urandom_range(3));
            k = $urandom_range(19);
            if (k == 0)
                gl = '0;
            else if (k == 1)
                gl = 16'hFFFF;
            else if (k == 2)
                gl = 16'd255 + srm_pkg::CNT_W'($urandom_range(2));
            else if (k < 6)
                gl = srm_pkg::CNT_W'($urandom_range(9, 40));
            else
                gl = srm_pkg::CNT_W'($urandom_range(1, 8));
            k = $urandom_range(19);
            if (k == 0)
                gc = '0;
            else if (k == 1)
                gc = 16'hFFFF;
            else if (k < 4)
                gc = srm_pkg::CNT_W'($urandom_range(6, 300));
            else
                gc = srm_pkg::CNT_W'($urandom_range(1, 5));
            configure(cur_mode, gc, gl);

            // one long stretch with both sides streaming flat out
            idle_on = !((beats_sent - rand_start) >= 700 && (beats_sent - rand_start) < 1100);
            phase_len = (gl >= 16'd255 && gl != 16'hFFFF) ?
                        int'(gl) + 30 : $urandom_range(20, 80);
            sess_left = 0;
            for (int n = 0; n < phase_len && beats_sent - rand_start < RANDOM_BEATS; n++)
            begin
                r = $urandom_range(99);
                if ((sess_left <= 0 && r < 60) || r < 3)
                begin
                    send_beat(srm_pkg::OP_START, srm_pkg::ADDR_W'($urandom),
                              srm_pkg::DATA_W'($urandom));
                    sess_left = (cur_mode < srm_pkg::MODE_ADDR_READ) ?
                                int'(gl) * int'(gc) : int'(gl);
                end
                else if (r < 6)
                begin
                    send_beat(srm_pkg::OP_STOP, srm_pkg::ADDR_W'($urandom),
                              srm_pkg::DATA_W'($urandom));
                    sess_left = 0;
                end
                else if (r < 10)
                    send_beat(srm_pkg::OP_SET_PTR, srm_pkg::ADDR_W'($urandom),
                              srm_pkg::DATA_W'($urandom));
                else if (r < 15)
                    send_beat(srm_pkg::OP_HOST_WRITE, srm_pkg::ADDR_W'($urandom),
                              srm_pkg::DATA_W'($urandom));
                else if (r < 20)
                    send_beat(srm_pkg::OP_HOST_READ, srm_pkg::ADDR_W'($urandom),
                              srm_pkg::DATA_W'($urandom));
                else if (r < 24)
                    send_beat(srm_pkg::OP_W'($urandom_range(7)), srm_pkg::ADDR_W'($urandom),
                              srm_pkg::DATA_W'($urandom));
                else
                begin
                    if (cur_mode == srm_pkg::MODE_ADDR_READ && $urandom_range(1) == 0)
                        send_beat(srm_pkg::OP_SPI, srm_pkg::ADDR_W'($urandom), '0);
                    else
                        send_beat(srm_pkg::OP_SPI, srm_pkg::ADDR_W'($urandom),
                                  srm_pkg::DATA_W'($urandom));
                    sess_left--;
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Sent %0d beats under %0d register settings across all four modes.",
                 beats_sent, settings_used);
        $display("%0d replies checked.", replies_seen);
        if (mismatches == 0 && replies_due == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
